>>> rtl/i2crm_pkg.sv
// ----------------------------------------------------------------------------
// i2crm_pkg - shared types and constants of the i2c register master
// Word layouts of the item and result channels, configuration write
// bundle, buffer sizing and configuration register indexes.
// ----------------------------------------------------------------------------
package i2crm_pkg;

    // write buffer sizing
    localparam int BUF_DEPTH = 16;
    localparam int BUF_IDX_W = 4;
    localparam int LEN_W     = 5;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = CFG_IDX_W'(1);

    localparam logic [CFG_DATA_W-1:0] RETRY_LIMIT_RST = 8'd10;
    localparam logic [CFG_DATA_W-1:0] PHASE_TICKS_RST = 8'd3;

    // input word
    typedef struct packed {
        logic [1:0]           cmd;
        logic [7:0]           device_addr;
        logic [15:0]          reg_addr;
        logic                 reg_wide;
        logic                 is_read;
        logic [LEN_W-1:0]     length;
        logic [BUF_IDX_W-1:0] byte_index;
        logic [7:0]           write_byte;
        logic                 sda_in;
    } t_in_word;

    // result word
    typedef struct packed {
        logic                 scl_out;
        logic                 sda_out;
        logic                 read_valid;
        logic [BUF_IDX_W-1:0] read_index;
        logic [7:0]           read_byte;
        logic                 busy_res;
        logic                 done_res;
        logic                 status;
    } t_out_word;

    // configuration write bundle
    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

>>> rtl/i2crm_seq.sv
// ----------------------------------------------------------------------------
// i2crm_seq - line phase sequencer
// Holds the transaction state, the write buffer and the configuration
// registers; advances one step per word and forms that word's result.
// ----------------------------------------------------------------------------
module i2crm_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  i2crm_pkg::t_in_word  i_word,
    input  i2crm_pkg::t_cfg_wr   i_cfg,
    output i2crm_pkg::t_out_word o_res
);

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_BEGIN = 2'd2;

    // segment codes
    localparam logic [3:0] SEG_IDLE    = 4'd0;
    localparam logic [3:0] SEG_STOP_A  = 4'd1;
    localparam logic [3:0] SEG_START_A = 4'd2;
    localparam logic [3:0] SEG_ID      = 4'd3;
    localparam logic [3:0] SEG_REGHI   = 4'd4;
    localparam logic [3:0] SEG_REGLO   = 4'd5;
    localparam logic [3:0] SEG_DATA    = 4'd6;
    localparam logic [3:0] SEG_STOP_M  = 4'd7;
    localparam logic [3:0] SEG_START_M = 4'd8;
    localparam logic [3:0] SEG_IDR     = 4'd9;
    localparam logic [3:0] SEG_READ    = 4'd10;
    localparam logic [3:0] SEG_STOP_F  = 4'd11;
    localparam logic [3:0] SEG_TAIL    = 4'd12;

    localparam logic [i2crm_pkg::LEN_W-1:0] DEPTH_L = i2crm_pkg::LEN_W'(i2crm_pkg::BUF_DEPTH);

    function automatic logic is_byte_seg(input logic [3:0] s);
        return (s == SEG_ID) || (s == SEG_REGHI) || (s == SEG_REGLO) || (s == SEG_DATA)
            || (s == SEG_IDR) || (s == SEG_READ);
    endfunction

    function automatic logic [2:0] seg_length(input logic [3:0] s);
        logic [2:0] len;
        case (s)
            SEG_STOP_A, SEG_STOP_M:   len = 3'd5;
            SEG_STOP_F:               len = 3'd4;
            SEG_START_A, SEG_START_M: len = 3'd3;
            default:                  len = 3'd1;
        endcase
        return len;
    endfunction

    // state registers
    logic [7:0]                  r_retry_limit, r_phase_ticks;
    logic [3:0]                  r_state, n_state;
    logic [2:0]                  r_sub, n_sub;
    logic [7:0]                  r_tick, n_tick;
    logic [3:0]                  r_bit, n_bit;
    logic [7:0]                  r_shift, n_shift;
    logic [i2crm_pkg::LEN_W-1:0] r_byte_count, n_byte_count;
    logic [7:0]                  r_attempt, n_attempt;
    logic                        r_pend_fail, n_pend_fail;
    logic [7:0]                  r_dev, n_dev;
    logic [15:0]                 r_reg, n_reg;
    logic                        r_wide, n_wide;
    logic                        r_rd, n_rd;
    logic [i2crm_pkg::LEN_W-1:0] r_len, n_len;
    logic                        r_scl, n_scl;
    logic                        r_sda, n_sda;
    logic [7:0]                  r_wbuf [i2crm_pkg::BUF_DEPTH];

    // step controls
    logic                        do_enter, do_act, do_fail;
    logic [3:0]                  enter_seg;
    logic [7:0]                  tick_lim, try_lim;
    logic                        ack;
    logic [i2crm_pkg::LEN_W-1:0] beg_len;
    logic                        em_valid, em_done, em_status;
    logic [i2crm_pkg::BUF_IDX_W-1:0] em_index;
    logic [7:0]                  em_byte;

    assign tick_lim = (r_phase_ticks == 8'd0) ? 8'd1 : r_phase_ticks;
    assign try_lim  = (r_retry_limit == 8'd0) ? 8'd1 : r_retry_limit;
    assign ack      = ~i_word.sda_in;

    // next state for one word
    always_comb begin
        n_state      = r_state;
        n_sub        = r_sub;
        n_tick       = r_tick;
        n_bit        = r_bit;
        n_shift      = r_shift;
        n_byte_count = r_byte_count;
        n_attempt    = r_attempt;
        n_pend_fail  = r_pend_fail;
        n_dev        = r_dev;
        n_reg        = r_reg;
        n_wide       = r_wide;
        n_rd         = r_rd;
        n_len        = r_len;
        n_scl        = r_scl;
        n_sda        = r_sda;
        do_enter     = 1'b0;
        do_act       = 1'b0;
        do_fail      = 1'b0;
        enter_seg    = SEG_IDLE;
        em_valid     = 1'b0;
        em_index     = '0;
        em_byte      = '0;
        em_done      = 1'b0;
        em_status    = 1'b0;
        beg_len      = (i_word.length > DEPTH_L) ? DEPTH_L : i_word.length;

        // command decode
        unique case (i_word.cmd)
            CMD_TICK: begin
                if (r_state != SEG_IDLE) begin
                    n_tick = r_tick + 8'd1;
                    if (n_tick >= tick_lim) begin
                        n_tick = 8'd0;
                        if (is_byte_seg(r_state)) begin
                            if (r_sub < 3'd2) begin
                                n_sub  = r_sub + 3'd1;
                                do_act = 1'b1;
                            end else if (r_bit < 4'd8) begin
                                n_shift = {r_shift[6:0],
                                           (r_state == SEG_READ) & i_word.sda_in};
                                n_bit   = r_bit + 4'd1;
                                n_sub   = 3'd0;
                                do_act  = 1'b1;
                            end else begin
                                // byte with its acknowledge slot is over
                                unique case (r_state)
                                    SEG_ID: begin
                                        if (!ack) begin
                                            do_fail = 1'b1;
                                        end else begin
                                            do_enter  = 1'b1;
                                            enter_seg = r_wide ? SEG_REGHI : SEG_REGLO;
                                        end
                                    end
                                    SEG_REGHI: begin
                                        do_enter  = 1'b1;
                                        enter_seg = SEG_REGLO;
                                    end
                                    SEG_REGLO: begin
                                        if (!ack) begin
                                            do_fail = 1'b1;
                                        end else if (r_rd) begin
                                            do_enter  = 1'b1;
                                            enter_seg = SEG_STOP_M;
                                        end else begin
                                            n_byte_count = '0;
                                            n_pend_fail  = 1'b0;
                                            do_enter     = 1'b1;
                                            enter_seg    = (r_len != '0) ? SEG_DATA
                                                                         : SEG_STOP_F;
                                        end
                                    end
                                    SEG_DATA: begin
                                        do_enter = 1'b1;
                                        if (!ack) begin
                                            n_pend_fail = 1'b1;
                                            enter_seg   = SEG_STOP_F;
                                        end else begin
                                            n_byte_count = r_byte_count + 1'b1;
                                            enter_seg    = (n_byte_count < r_len) ? SEG_DATA
                                                                                  : SEG_STOP_F;
                                        end
                                    end
                                    SEG_IDR: begin
                                        if (!ack) begin
                                            do_fail = 1'b1;
                                        end else begin
                                            n_byte_count = '0;
                                            n_pend_fail  = 1'b0;
                                            do_enter     = 1'b1;
                                            enter_seg    = SEG_READ;
                                        end
                                    end
                                    default: begin
                                        em_valid     = 1'b1;
                                        em_index     = r_byte_count[i2crm_pkg::BUF_IDX_W-1:0];
                                        em_byte      = r_shift;
                                        n_byte_count = r_byte_count + 1'b1;
                                        do_enter     = 1'b1;
                                        enter_seg    = (n_byte_count < r_len) ? SEG_READ
                                                                              : SEG_STOP_F;
                                    end
                                endcase
                            end
                        end else if ((r_sub + 3'd1) < seg_length(r_state)) begin
                            n_sub  = r_sub + 3'd1;
                            do_act = 1'b1;
                        end else begin
                            // end of a line segment
                            unique case (r_state)
                                SEG_STOP_A: begin
                                    do_enter  = 1'b1;
                                    enter_seg = SEG_START_A;
                                end
                                SEG_START_A: begin
                                    do_enter  = 1'b1;
                                    enter_seg = SEG_ID;
                                end
                                SEG_STOP_M: begin
                                    do_enter  = 1'b1;
                                    enter_seg = SEG_START_M;
                                end
                                SEG_START_M: begin
                                    do_enter  = 1'b1;
                                    enter_seg = SEG_IDR;
                                end
                                SEG_STOP_F: begin
                                    do_enter = 1'b1;
                                    if (r_pend_fail && (r_attempt < try_lim)) begin
                                        n_attempt   = r_attempt + 8'd1;
                                        n_pend_fail = 1'b0;
                                        enter_seg   = SEG_STOP_A;
                                    end else begin
                                        enter_seg = SEG_TAIL;
                                    end
                                end
                                default: begin
                                    n_state   = SEG_IDLE;
                                    n_sub     = 3'd0;
                                    n_tick    = 8'd0;
                                    em_done   = 1'b1;
                                    em_status = r_pend_fail;
                                end
                            endcase
                        end
                    end
                end
            end
            CMD_LOAD: begin
                // buffer write handled in the clocked block
            end
            CMD_BEGIN: begin
                if (r_state == SEG_IDLE) begin
                    n_dev        = i_word.device_addr;
                    n_reg        = i_word.reg_wide ? i_word.reg_addr
                                                   : {8'd0, i_word.reg_addr[7:0]};
                    n_wide       = i_word.reg_wide;
                    n_rd         = i_word.is_read;
                    n_len        = (i_word.is_read && beg_len == '0)
                                   ? i2crm_pkg::LEN_W'(1) : beg_len;
                    n_attempt    = 8'd1;
                    n_byte_count = '0;
                    n_pend_fail  = 1'b0;
                    do_enter     = 1'b1;
                    enter_seg    = SEG_STOP_A;
                end
            end
            default: begin
            end
        endcase

        // missing acknowledge: retry or give up
        if (do_fail) begin
            do_enter = 1'b1;
            if (r_attempt < try_lim) begin
                n_attempt = r_attempt + 8'd1;
                enter_seg = SEG_STOP_A;
            end else begin
                n_pend_fail = 1'b1;
                enter_seg   = SEG_TAIL;
            end
        end

        // segment entry
        if (do_enter) begin
            n_state = enter_seg;
            n_sub   = 3'd0;
            n_bit   = 4'd0;
            n_tick  = 8'd0;
            do_act  = 1'b1;
            case (enter_seg)
                SEG_ID:    n_shift = n_dev;
                SEG_REGHI: n_shift = n_reg[15:8];
                SEG_REGLO: n_shift = n_reg[7:0];
                SEG_DATA:  n_shift = (n_byte_count < DEPTH_L)
                                     ? r_wbuf[n_byte_count[i2crm_pkg::BUF_IDX_W-1:0]] : 8'd0;
                SEG_IDR:   n_shift = n_dev | 8'h01;
                SEG_READ:  n_shift = 8'd0;
                default:   n_shift = n_shift;
            endcase
        end

        // line levels for the phase just entered
        if (do_act) begin
            if (is_byte_seg(n_state)) begin
                if (n_sub == 3'd0) begin
                    n_scl = 1'b0;
                end else if (n_sub == 3'd2) begin
                    n_scl = 1'b1;
                end else if (n_state == SEG_READ) begin
                    n_sda = (n_bit < 4'd8) ? 1'b1
                          : (({1'b0, n_byte_count} + 6'd1) >= {1'b0, n_len});
                end else begin
                    n_sda = (n_bit < 4'd8) ? n_shift[7] : 1'b1;
                end
            end else begin
                case (n_state) inside
                    SEG_STOP_A, SEG_STOP_M, SEG_STOP_F: begin
                        case (n_sub)
                            3'd0:    n_scl = 1'b0;
                            3'd1:    n_sda = 1'b0;
                            3'd2:    n_scl = 1'b1;
                            3'd3:    n_sda = 1'b1;
                            default: n_scl = n_scl;
                        endcase
                    end
                    SEG_START_A, SEG_START_M: begin
                        if (n_sub == 3'd0) begin
                            n_scl = 1'b1;
                        end else if (n_sub == 3'd1) begin
                            n_sda = 1'b1;
                        end else begin
                            n_sda = 1'b0;
                        end
                    end
                    default: n_sda = n_sda;
                endcase
            end
        end
    end

    // result of this word
    always_comb begin
        o_res.scl_out    = n_scl;
        o_res.sda_out    = n_sda;
        o_res.read_valid = em_valid;
        o_res.read_index = em_index;
        o_res.read_byte  = em_byte;
        o_res.busy_res   = (n_state != SEG_IDLE);
        o_res.done_res   = em_done;
        o_res.status     = em_status;
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= SEG_IDLE;
            r_sub        <= 3'd0;
            r_tick       <= 8'd0;
            r_bit        <= 4'd0;
            r_shift      <= 8'd0;
            r_byte_count <= '0;
            r_attempt    <= 8'd0;
            r_pend_fail  <= 1'b0;
            r_dev        <= 8'd0;
            r_reg        <= 16'd0;
            r_wide       <= 1'b0;
            r_rd         <= 1'b0;
            r_len        <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
        end else if (i_step) begin
            r_state      <= n_state;
            r_sub        <= n_sub;
            r_tick       <= n_tick;
            r_bit        <= n_bit;
            r_shift      <= n_shift;
            r_byte_count <= n_byte_count;
            r_attempt    <= n_attempt;
            r_pend_fail  <= n_pend_fail;
            r_dev        <= n_dev;
            r_reg        <= n_reg;
            r_wide       <= n_wide;
            r_rd         <= n_rd;
            r_len        <= n_len;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= i2crm_pkg::RETRY_LIMIT_RST;
            r_phase_ticks <= i2crm_pkg::PHASE_TICKS_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                i2crm_pkg::CFG_RETRY_LIMIT: r_retry_limit <= i_cfg.data;
                i2crm_pkg::CFG_PHASE_TICKS: r_phase_ticks <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // write buffer
    always_ff @(posedge i_clk) begin
        if (i_step && i_word.cmd == CMD_LOAD) begin
            r_wbuf[i_word.byte_index] <= i_word.write_byte;
        end
    end

    // checks
    a_busy_has_attempt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != SEG_IDLE) |-> (r_attempt != 8'd0))
        else $error("busy with no attempt counted");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit <= 4'd8) && (r_byte_count <= DEPTH_L))
        else $error("bit or byte counter out of range");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.done_res) |=> (r_state == SEG_IDLE))
        else $error("done reported without returning to idle");

    a_byte_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_byte_seg(r_state) |-> (r_sub <= 3'd2))
        else $error("byte segment phase out of range");

endmodule

>>> rtl/i2c_register_master_core.sv
// ----------------------------------------------------------------------------
// i2c_register_master_core - i2c register transaction master
// Data path: an accepted word is held in the input word register; its result
//   word is registered in the result word register when the sequencer steps.
// Throughput: one word per sequencer step, each cycle unless output stalls.
// Reset: synchronous active low; idle, lines released, retry limit 10,
//   phase ticks 3; write buffer contents undefined until loaded.
// ----------------------------------------------------------------------------
module i2c_register_master_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  i2crm_pkg::t_in_word                 i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output i2crm_pkg::t_out_word                o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [i2crm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [i2crm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic                 r_in_valid;
    i2crm_pkg::t_in_word  r_in_word;
    logic                 r_out_valid;
    i2crm_pkg::t_out_word r_out_word;
    i2crm_pkg::t_out_word seq_res;
    i2crm_pkg::t_cfg_wr   cfg_wr;
    logic                 in_take;
    logic                 step;

    // handshake control
    assign step        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !step;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // configuration write bundle
    always_comb begin
        cfg_wr.we    = i_cfg_valid && o_cfg_ready;
        cfg_wr.index = i_cfg_index;
        cfg_wr.data  = i_cfg_data;
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
    end

    // sequencer
    i2crm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_word  (r_in_word),
        .i_cfg   (cfg_wr),
        .o_res   (seq_res)
    );

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_word <= seq_res;
        end
    end

endmodule
